>>> rtl/mwu_pkg.sv
package mwu_pkg;

    // Store geometry
    localparam int PARAM_COUNT = 1024;
    localparam int ADDR_W      = $clog2(PARAM_COUNT);

    // Field widths
    localparam int IDX_W    = 10;
    localparam int DATA_W   = 32;
    localparam int GAIN_W   = 16;
    localparam int S_DATA_W = 48;
    localparam int M_DATA_W = 80;

    // Fixed point arithmetic
    localparam int FRAC_SHIFT = 15;
    localparam int ROUND_HALF = 1 << (FRAC_SHIFT - 1);
    localparam int PROD_W     = DATA_W + GAIN_W + 1;
    localparam int SUM_W      = PROD_W + 1;
    localparam int RND_W      = SUM_W - FRAC_SHIFT;
    localparam int WIDE_W     = RND_W + 1;

    // Configuration port
    localparam int APB_ADDR_W = 4;
    localparam int APB_DATA_W = 32;
    localparam int REG_SEL_W  = 2;

    localparam logic [REG_SEL_W-1:0] REG_STEP_SIZE = 2'd0;
    localparam logic [REG_SEL_W-1:0] REG_REG_GAIN  = 2'd1;
    localparam logic [REG_SEL_W-1:0] REG_MOMENTUM  = 2'd2;

    localparam logic [GAIN_W-1:0] RATE_RESET     = 16'd328;
    localparam logic [GAIN_W-1:0] REG_GAIN_RESET = 16'd0;
    localparam logic [GAIN_W-1:0] MOMENTUM_RESET = 16'd29491;

    // Operation codes
    localparam logic OP_LOAD   = 1'b0;
    localparam logic OP_UPDATE = 1'b1;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_MUL1,
        ST_ADD1,
        ST_MUL2,
        ST_SUM,
        ST_FIN,
        ST_WB
    } state_t;

    typedef struct packed {
        logic              accept;
        logic              clr_wr;
        logic [ADDR_W-1:0] clr_addr;
        logic              ld_mul1;
        logic              ld_add1;
        logic              ld_mul2;
        logic              ld_sum;
        logic              ld_fin;
        logic              wb;
    } cmd_t;

    typedef struct packed {
        logic op_update;
        logic out_busy;
    } stat_t;

    typedef struct packed {
        logic [GAIN_W-1:0] rate;
        logic [GAIN_W-1:0] reg_gain;
        logic [GAIN_W-1:0] decay;
    } gains_t;

    // Round to nearest, ties toward plus infinity, then drop the Q15 fraction
    function automatic logic signed [RND_W-1:0] rnd_q15(input logic signed [SUM_W-1:0] p);
        logic signed [SUM_W-1:0] q;
        q = p + SUM_W'(ROUND_HALF);
        return q[SUM_W-1:FRAC_SHIFT];
    endfunction

    // Clamp to the signed 32 bit range
    function automatic logic signed [DATA_W-1:0] sat32(input logic signed [WIDE_W-1:0] x);
        logic [WIDE_W-DATA_W:0] top;
        top = x[WIDE_W-1:DATA_W-1];
        if ((&top) || !(|top))
        begin
            return x[DATA_W-1:0];
        end
        else if (x[WIDE_W-1])
        begin
            return {1'b1, {(DATA_W-1){1'b0}}};
        end
        else
        begin
            return {1'b0, {(DATA_W-1){1'b1}}};
        end
    endfunction

endpackage

>>> rtl/mwu_ram.sv
module mwu_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

>>> rtl/mwu_cfg.sv
module mwu_cfg (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 psel,
    input  logic                                 penable,
    input  logic                                 pwrite,
    input  logic [mwu_pkg::APB_ADDR_W-1:0]       paddr,
    input  logic [mwu_pkg::APB_DATA_W-1:0]       pwdata,
    output logic [mwu_pkg::APB_DATA_W-1:0]       prdata,
    output mwu_pkg::gains_t                      gains
);

    mwu_pkg::gains_t                  gains_reg;
    mwu_pkg::gains_t                  gains_next;
    logic                             wr;
    logic [mwu_pkg::REG_SEL_W-1:0]    sel;
    logic [mwu_pkg::GAIN_W-1:0]       wval;

    assign wr   = psel & penable & pwrite;
    assign sel  = paddr[mwu_pkg::APB_ADDR_W-1:2];
    assign wval = pwdata[mwu_pkg::GAIN_W-1:0];

    always_comb
    begin
        gains_next = gains_reg;
        if (wr)
        begin
            unique case (sel)
                mwu_pkg::REG_STEP_SIZE: gains_next.rate     = wval;
                mwu_pkg::REG_REG_GAIN:  gains_next.reg_gain = wval;
                mwu_pkg::REG_MOMENTUM:  gains_next.decay    = wval;
                default:                gains_next          = gains_reg;
            endcase
        end
    end

    always_comb
    begin
        unique case (sel)
            mwu_pkg::REG_STEP_SIZE:
                prdata = mwu_pkg::APB_DATA_W'(gains_reg.rate);
            mwu_pkg::REG_REG_GAIN:
                prdata = mwu_pkg::APB_DATA_W'(gains_reg.reg_gain);
            mwu_pkg::REG_MOMENTUM:
                prdata = mwu_pkg::APB_DATA_W'(gains_reg.decay);
            default:
                prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gains_reg.rate     <= mwu_pkg::RATE_RESET;
            gains_reg.reg_gain <= mwu_pkg::REG_GAIN_RESET;
            gains_reg.decay    <= mwu_pkg::MOMENTUM_RESET;
        end
        else
        begin
            gains_reg <= gains_next;
        end
    end

    assign gains = gains_reg;

endmodule

>>> rtl/mwu_ctrl.sv
module mwu_ctrl (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           s_tvalid,
    output logic           s_tready,
    input  mwu_pkg::stat_t stat,
    output mwu_pkg::cmd_t  cmd
);

    localparam logic [mwu_pkg::ADDR_W-1:0] CLR_LAST = mwu_pkg::ADDR_W'(mwu_pkg::PARAM_COUNT - 1);

    mwu_pkg::state_t               state_reg;
    mwu_pkg::state_t               state_next;
    logic [mwu_pkg::ADDR_W-1:0]    clr_cnt_reg;
    logic [mwu_pkg::ADDR_W-1:0]    clr_cnt_next;

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            mwu_pkg::ST_CLEAR:
            begin
                if (clr_cnt_reg == CLR_LAST)
                begin
                    state_next = mwu_pkg::ST_IDLE;
                end
            end
            mwu_pkg::ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    state_next = mwu_pkg::ST_MUL1;
                end
            end
            mwu_pkg::ST_MUL1:
            begin
                state_next = stat.op_update ? mwu_pkg::ST_ADD1 : mwu_pkg::ST_WB;
            end
            mwu_pkg::ST_ADD1: state_next = mwu_pkg::ST_MUL2;
            mwu_pkg::ST_MUL2: state_next = mwu_pkg::ST_SUM;
            mwu_pkg::ST_SUM:  state_next = mwu_pkg::ST_FIN;
            mwu_pkg::ST_FIN:  state_next = mwu_pkg::ST_WB;
            mwu_pkg::ST_WB:
            begin
                if (!stat.out_busy)
                begin
                    state_next = mwu_pkg::ST_IDLE;
                end
            end
            default: state_next = mwu_pkg::ST_IDLE;
        endcase
    end

    // Outputs
    always_comb
    begin
        cmd          = '0;
        cmd.clr_addr = clr_cnt_reg;
        clr_cnt_next = clr_cnt_reg;
        s_tready     = 1'b0;
        unique case (state_reg)
            mwu_pkg::ST_CLEAR:
            begin
                cmd.clr_wr   = 1'b1;
                clr_cnt_next = clr_cnt_reg + 1'b1;
            end
            mwu_pkg::ST_IDLE:
            begin
                s_tready   = 1'b1;
                cmd.accept = s_tvalid;
            end
            mwu_pkg::ST_MUL1: cmd.ld_mul1 = 1'b1;
            mwu_pkg::ST_ADD1: cmd.ld_add1 = 1'b1;
            mwu_pkg::ST_MUL2: cmd.ld_mul2 = 1'b1;
            mwu_pkg::ST_SUM:  cmd.ld_sum  = 1'b1;
            mwu_pkg::ST_FIN:  cmd.ld_fin  = 1'b1;
            mwu_pkg::ST_WB:   cmd.wb      = !stat.out_busy;
            default:          cmd         = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= mwu_pkg::ST_CLEAR;
            clr_cnt_reg <= '0;
        end
        else
        begin
            state_reg   <= state_next;
            clr_cnt_reg <= clr_cnt_next;
        end
    end

    a_no_accept_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.clr_wr |-> !cmd.accept && !cmd.wb)
        else $error("item taken during velocity clear");

    a_accept_leaves_idle: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.accept |=> state_reg == mwu_pkg::ST_MUL1)
        else $error("accepted word did not start processing");

    a_wb_only_when_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.wb |-> !stat.out_busy)
        else $error("result written over a waiting word");

    a_mul2_after_add1: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == mwu_pkg::ST_MUL2 |-> $past(state_reg) == mwu_pkg::ST_ADD1)
        else $error("weight product started without new velocity");

endmodule

>>> rtl/mwu_dp.sv
module mwu_dp (
    input  logic                               clk,
    input  logic                               rst_n,
    input  mwu_pkg::cmd_t                      cmd,
    output mwu_pkg::stat_t                     stat,
    input  mwu_pkg::gains_t                    gains,
    input  logic                               in_op,
    input  logic [mwu_pkg::IDX_W-1:0]          in_index,
    input  logic signed [mwu_pkg::DATA_W-1:0]  in_value,
    output logic                               out_valid,
    input  logic                               out_ready,
    output logic [mwu_pkg::IDX_W-1:0]          out_index,
    output logic signed [mwu_pkg::DATA_W-1:0]  out_weight,
    output logic signed [mwu_pkg::DATA_W-1:0]  out_velocity
);

    localparam int ADDR_W = mwu_pkg::ADDR_W;
    localparam int DATA_W = mwu_pkg::DATA_W;
    localparam int IDX_W  = mwu_pkg::IDX_W;
    localparam int PROD_W = mwu_pkg::PROD_W;
    localparam int SUM_W  = mwu_pkg::SUM_W;
    localparam int RND_W  = mwu_pkg::RND_W;
    localparam int WIDE_W = mwu_pkg::WIDE_W;
    localparam int FS     = mwu_pkg::FRAC_SHIFT;

    // Item registers
    logic                      op_reg,       op_next;
    logic [IDX_W-1:0]          idx_reg,      idx_next;
    logic signed [DATA_W-1:0]  val_reg,      val_next;
    logic                      in_range_reg, in_range_next;

    // Arithmetic registers
    logic signed [DATA_W-1:0]  w_reg,    w_next;
    logic signed [PROD_W-1:0]  p1_reg,   p1_next;
    logic signed [DATA_W-1:0]  vnew_reg, vnew_next;
    logic signed [PROD_W-1:0]  pa_reg,   pa_next;
    logic signed [PROD_W-1:0]  pb_reg,   pb_next;
    logic signed [SUM_W-1:0]   t_reg,    t_next;
    logic signed [DATA_W-1:0]  wnew_reg, wnew_next;

    // Output word
    logic                      out_valid_reg, out_valid_next;
    logic [IDX_W-1:0]          oidx_reg,      oidx_next;
    logic signed [DATA_W-1:0]  ow_reg,        ow_next;
    logic signed [DATA_W-1:0]  ov_reg,        ov_next;

    // Store ports
    logic [DATA_W-1:0]         w_rdata;
    logic [DATA_W-1:0]         v_rdata;
    logic                      w_wr_en;
    logic                      v_wr_en;
    logic [ADDR_W-1:0]         v_wr_addr;
    logic signed [DATA_W-1:0]  wb_w;
    logic signed [DATA_W-1:0]  wb_v;

    logic signed [RND_W-1:0]   rnd_v;
    logic signed [WIDE_W-1:0]  vsum;
    logic signed [WIDE_W-1:0]  wdiff;

    mwu_ram #(.WIDTH(DATA_W), .DEPTH(mwu_pkg::PARAM_COUNT)) u_weight_ram (
        .clk     (clk),
        .wr_en   (w_wr_en),
        .wr_addr (idx_reg[ADDR_W-1:0]),
        .wr_data (wb_w),
        .rd_en   (cmd.accept),
        .rd_addr (in_index[ADDR_W-1:0]),
        .rd_data (w_rdata)
    );

    mwu_ram #(.WIDTH(DATA_W), .DEPTH(mwu_pkg::PARAM_COUNT)) u_velocity_ram (
        .clk     (clk),
        .wr_en   (v_wr_en),
        .wr_addr (v_wr_addr),
        .wr_data (cmd.clr_wr ? '0 : wb_v),
        .rd_en   (cmd.accept),
        .rd_addr (in_index[ADDR_W-1:0]),
        .rd_data (v_rdata)
    );

    // Writeback values: load takes the operand, an index past the store returns zeros
    always_comb
    begin
        if (!in_range_reg)
        begin
            wb_w = '0;
            wb_v = '0;
        end
        else if (op_reg == mwu_pkg::OP_UPDATE)
        begin
            wb_w = wnew_reg;
            wb_v = vnew_reg;
        end
        else
        begin
            wb_w = val_reg;
            wb_v = '0;
        end
    end

    assign w_wr_en   = cmd.wb & in_range_reg;
    assign v_wr_en   = cmd.clr_wr | (cmd.wb & in_range_reg);
    assign v_wr_addr = cmd.clr_wr ? cmd.clr_addr : idx_reg[ADDR_W-1:0];

    always_comb
    begin
        op_next       = op_reg;
        idx_next      = idx_reg;
        val_next      = val_reg;
        in_range_next = in_range_reg;
        if (cmd.accept)
        begin
            op_next       = in_op;
            idx_next      = in_index;
            val_next      = in_value;
            in_range_next = ({1'b0, in_index} < (IDX_W + 1)'(mwu_pkg::PARAM_COUNT));
        end
    end

    always_comb
    begin
        w_next    = w_reg;
        p1_next   = p1_reg;
        vnew_next = vnew_reg;
        pa_next   = pa_reg;
        pb_next   = pb_reg;
        t_next    = t_reg;
        wnew_next = wnew_reg;

        rnd_v = mwu_pkg::rnd_q15(SUM_W'(p1_reg));
        vsum  = WIDE_W'(rnd_v) + WIDE_W'(val_reg);
        wdiff = WIDE_W'(w_reg) - WIDE_W'($signed(t_reg[SUM_W-1:FS]));

        if (cmd.ld_mul1)
        begin
            w_next  = $signed(w_rdata);
            p1_next = $signed(v_rdata) * $signed({1'b0, gains.decay});
        end
        if (cmd.ld_add1)
        begin
            vnew_next = mwu_pkg::sat32(vsum);
        end
        if (cmd.ld_mul2)
        begin
            pa_next = vnew_reg * $signed({1'b0, gains.rate});
            pb_next = w_reg * $signed({1'b0, gains.reg_gain});
        end
        if (cmd.ld_sum)
        begin
            // fold the rounding half in so the final stage only subtracts
            t_next = SUM_W'(pa_reg) + SUM_W'(pb_reg) + SUM_W'(mwu_pkg::ROUND_HALF);
        end
        if (cmd.ld_fin)
        begin
            wnew_next = mwu_pkg::sat32(wdiff);
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        oidx_next      = oidx_reg;
        ow_next        = ow_reg;
        ov_next        = ov_reg;
        if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        if (cmd.wb)
        begin
            out_valid_next = 1'b1;
            oidx_next      = idx_reg;
            ow_next        = wb_w;
            ov_next        = wb_v;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg       <= op_next;
        idx_reg      <= idx_next;
        val_reg      <= val_next;
        in_range_reg <= in_range_next;
        w_reg        <= w_next;
        p1_reg       <= p1_next;
        vnew_reg     <= vnew_next;
        pa_reg       <= pa_next;
        pb_reg       <= pb_next;
        t_reg        <= t_next;
        wnew_reg     <= wnew_next;
        oidx_reg     <= oidx_next;
        ow_reg       <= ow_next;
        ov_reg       <= ov_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    assign stat.op_update = (op_reg == mwu_pkg::OP_UPDATE);
    assign stat.out_busy  = out_valid_reg & ~out_ready;

    assign out_valid    = out_valid_reg;
    assign out_index    = oidx_reg;
    assign out_weight   = ow_reg;
    assign out_velocity = ov_reg;

endmodule

>>> rtl/momentum_weight_updater_top.sv
// Channel   Dir  Handshake          Payload
// s_*       in   s_tvalid/s_tready  s_tuser: operation; s_tdata: index, operand_value
// m_*       out  m_tvalid/m_tready  m_tdata: result_index, new_weight, new_velocity
// apb       in   psel/penable       0x0 step_size, 0x4 regularization_gain,
//                                   0x8 momentum_decay (16 bit each)
//
// An update word steps through MUL1, ADD1, MUL2, SUM and FIN to writeback (WB), a load
// word goes from MUL1 straight to WB; a new word is taken only in IDLE, once the last
// one has left WB. The update sequence is set by the registered store read and the two
// dependent multiply stages (decay*velocity, then rate*velocity + gain*weight)
// sharing one sequencer. After reset the velocity store is cleared one entry a cycle
// (all 1024 entries), with s_tready low; configuration writes are taken throughout.
// A finished word sits in the output register; the next input word is accepted while
// it waits, and its result holds in writeback until the output register frees up.
module momentum_weight_updater_top (
    input  logic                                clk,
    input  logic                                rst_n,

    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [mwu_pkg::S_DATA_W-1:0]        s_tdata,  // [9:0] index, [41:10] operand_value
    input  logic [0:0]                          s_tuser,  // [0] operation

    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [mwu_pkg::M_DATA_W-1:0]        m_tdata,  // [9:0] result_index,
                                                          // [41:10] new_weight,
                                                          // [73:42] new_velocity

    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [mwu_pkg::APB_ADDR_W-1:0]      paddr,
    input  logic [mwu_pkg::APB_DATA_W-1:0]      pwdata,
    output logic [mwu_pkg::APB_DATA_W-1:0]      prdata,
    output logic                                pready
);

    localparam int IDX_W  = mwu_pkg::IDX_W;
    localparam int DATA_W = mwu_pkg::DATA_W;

    mwu_pkg::cmd_t             cmd;
    mwu_pkg::stat_t            stat;
    mwu_pkg::gains_t           gains;
    logic [IDX_W-1:0]          out_index;
    logic signed [DATA_W-1:0]  out_weight;
    logic signed [DATA_W-1:0]  out_velocity;

    assign pready = 1'b1;

    mwu_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .gains   (gains)
    );

    mwu_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    mwu_dp u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .stat         (stat),
        .gains        (gains),
        .in_op        (s_tuser[0]),
        .in_index     (s_tdata[IDX_W-1:0]),
        .in_value     ($signed(s_tdata[IDX_W+DATA_W-1:IDX_W])),
        .out_valid    (m_tvalid),
        .out_ready    (m_tready),
        .out_index    (out_index),
        .out_weight   (out_weight),
        .out_velocity (out_velocity)
    );

    assign m_tdata = {{(mwu_pkg::M_DATA_W - IDX_W - 2 * DATA_W){1'b0}},
                      out_velocity, out_weight, out_index};

endmodule
